// ===== hdl/block_bump_allocator_top_macros.svh =====
// assertion macros for the bump allocator top level
`ifndef BLOCK_BUMP_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_BUMP_ALLOCATOR_TOP_MACROS_SVH

// consequent checked in the same cycle
`define BBA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bump allocator check failed");

// consequent checked in the next cycle
`define BBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bump allocator check failed");

`endif

// ===== hdl/bba_pkg.sv =====
// shared types and constants for the block bump allocator
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam int BASE_W  = 48;
  localparam int BS_W    = 25;
  localparam int BC_W    = 7;
  localparam int SIZE_W  = 24;
  localparam int ALIGN_W = 17;
  localparam int OFF_W   = 30;
  localparam int LIVE_W  = 25;
  localparam int FP_W    = 31;
  localparam int PROD_W  = 32;
  localparam int OFFS_W  = 32;
  localparam int END_W   = 33;
  localparam int GOT_W   = 33;
  localparam int DVD_W   = 49;
  localparam int DVS_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [BS_W-1:0]   BS_MAX = 25'h1000000;
  localparam logic [BS_W-1:0]   BS_RST = 25'd65536;
  localparam logic [BC_W-1:0]   BC_RST = 7'd64;
  localparam logic [BASE_W-1:0] BASE_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE   = 2'd0,
    CFG_BSIZE  = 2'd1,
    CFG_BCOUNT = 2'd2
  } bba_cfg_idx_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } bba_req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_FREE = 2'd3
  } bba_status_t;

  typedef struct packed {
    bba_req_t            req_type;
    logic [SIZE_W-1:0]   size;
    logic [ALIGN_W-1:0]  alignment;
    logic [OFF_W-1:0]    free_offset;
  } bba_in_t;

  typedef struct packed {
    bba_status_t         status;
    logic [OFF_W-1:0]    offset;
    logic [SIZE_W-1:0]   granted_size;
  } bba_out_t;

  // effective configuration after clamping
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [BS_W-1:0]   bs;
    logic [BC_W-1:0]   cnt;
  } bba_cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_CUR_RD,
    S_A_CUR,
    S_A_POP,
    S_A_POP_RD,
    S_A_POP_MUL,
    S_A_DIV,
    S_A_FIT,
    S_F_CHK,
    S_F_RANGE,
    S_F_DIV,
    S_F_WAIT,
    S_F_UPD
  } bba_state_t;

endpackage

// ===== hdl/bba_div.sv =====
// shared restoring divider, one quotient bit per cycle
module bba_div import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dq_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic             q_bit;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dq_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits fill in at the bottom
  always_ff @(posedge clk) begin
    if (go) begin
      dq_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[DVD_W-2:0], q_bit};
    end
  end

  assign done      = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/bba_ctrl.sv =====
// request sequencer, block tables and free stack of the bump allocator
module bba_ctrl import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     init,
  input  bba_cfg_t cfg,
  input  logic     start,
  input  bba_in_t  in_data,
  output logic     busy,
  output logic     res_valid,
  output bba_out_t res
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int FC_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (IDX_W > BC_W) ? IDX_W : BC_W;

  bba_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  clr_cnt_r;
  logic [FC_W-1:0]   free_cnt_r;
  logic [IDX_W-1:0]  cur_idx_r;
  logic              cur_vld_r;
  logic              res_valid_r;
  bba_out_t          res_r;

  bba_in_t           req_r;
  logic [IDX_W-1:0]  idx_r;
  logic              fresh_r;
  logic [PROD_W-1:0] prod_r;
  logic [END_W-1:0]  end_r;
  logic [OFFS_W-1:0] off_r;
  logic [GOT_W-1:0]  got_r;

  logic [FP_W-1:0]   fp_mem   [MAX_BLOCKS];
  logic [IDX_W-1:0]  stk_mem  [MAX_BLOCKS];
  logic [LIVE_W-1:0] live_mem [MAX_BLOCKS];
  logic [FP_W-1:0]   fp_q;
  logic [IDX_W-1:0]  stk_q;
  logic [LIVE_W-1:0] live_q;

  logic              accept;
  logic              clr_last;
  logic              size_bad;
  logic              fits;
  logic              range_bad;
  logic              live_zero;
  logic              live_last;
  logic              pop_commit;
  logic              push;
  logic              drop_cur;
  logic [ALIGN_W-1:0] a_eff;
  logic [ALIGN_W-1:0] pad;
  logic [GOT_W-1:0]  got_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic [IDX_W-1:0]  stk_init;
  logic [IDX_W-1:0]  stk_raddr;

  // outputs of the sequencer and the divider
  logic              fin;
  bba_status_t       fin_status;
  logic              fin_grant;
  logic [BC_W-1:0]   mul_a;
  logic              div_go;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [DVS_W-1:0]  div_rem;
  logic              fp_we;
  logic [FP_W-1:0]   fp_wdata;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;
  logic [IDX_W-1:0]  stk_wdata;
  logic              live_we;
  logic [IDX_W-1:0]  live_waddr;
  logic [LIVE_W-1:0] live_wdata;

  bba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign clr_last  = (clr_cnt_r == IDX_W'(MAX_BLOCKS - 1));
  assign size_bad  = (req_r.size == '0) || (BS_W'(req_r.size) >= cfg.bs);
  assign fits      = ((GOT_W + 1)'(got_r) + (GOT_W + 1)'(req_r.size)) <= (GOT_W + 1)'(end_r);
  assign range_bad = (PROD_W'(req_r.free_offset) >= prod_r);
  assign live_zero = (live_q == '0);
  assign live_last = (live_q == LIVE_W'(1));
  assign stk_raddr = IDX_W'(free_cnt_r - FC_W'(1));

  assign a_eff    = (req_r.alignment == '0) ? ALIGN_W'(1) : req_r.alignment;
  // distance to the next aligned absolute address
  assign pad      = (div_rem[ALIGN_W-1:0] == '0) ? '0 : a_eff - div_rem[ALIGN_W-1:0];
  assign got_nxt  = GOT_W'(off_r) + GOT_W'(pad);
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(cfg.bs);

  assign stk_init = (CMP_W'(clr_cnt_r) < CMP_W'(cfg.cnt)) ?
                    IDX_W'(CMP_W'(cfg.cnt) - CMP_W'(clr_cnt_r) - CMP_W'(1)) : '0;

  assign pop_commit = (state_r == S_A_FIT) && fits && fresh_r;
  assign push       = (state_r == S_F_UPD) && live_last &&
                      (free_cnt_r < FC_W'(MAX_BLOCKS));
  assign drop_cur   = (state_r == S_F_UPD) && live_last && cur_vld_r &&
                      (cur_idx_r == idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) state_nxt = (in_data.req_type == REQ_FREE) ? S_F_CHK : S_A_CHK;
      end
      S_A_CHK: begin
        if (size_bad)       state_nxt = S_IDLE;
        else if (cur_vld_r) state_nxt = S_A_CUR_RD;
        else                state_nxt = S_A_POP;
      end
      S_A_CUR_RD:  state_nxt = S_A_CUR;
      S_A_CUR:     state_nxt = S_A_DIV;
      S_A_POP:     state_nxt = (free_cnt_r == '0) ? S_IDLE : S_A_POP_RD;
      S_A_POP_RD:  state_nxt = S_A_POP_MUL;
      S_A_POP_MUL: state_nxt = S_A_DIV;
      S_A_DIV:     if (div_done) state_nxt = S_A_FIT;
      S_A_FIT:     state_nxt = (fits || fresh_r) ? S_IDLE : S_A_POP;
      S_F_CHK:     state_nxt = S_F_RANGE;
      S_F_RANGE:   state_nxt = range_bad ? S_IDLE : S_F_DIV;
      S_F_DIV:     if (div_done) state_nxt = S_F_WAIT;
      S_F_WAIT:    state_nxt = S_F_UPD;
      S_F_UPD:     state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_grant  = 1'b0;
    mul_a      = '0;
    div_go     = 1'b0;
    div_dvd    = DVD_W'(req_r.free_offset);
    div_dvs    = (req_r.req_type == REQ_FREE) ? cfg.bs : DVS_W'(a_eff);
    fp_we      = 1'b0;
    fp_wdata   = FP_W'(got_r + GOT_W'(req_r.size));
    stk_we     = 1'b0;
    stk_waddr  = IDX_W'(free_cnt_r);
    stk_wdata  = idx_r;
    live_we    = 1'b0;
    live_waddr = idx_r;
    live_wdata = live_q + LIVE_W'(1);
    unique case (state_r)
      S_CLEAR: begin
        live_we    = 1'b1;
        live_waddr = clr_cnt_r;
        live_wdata = '0;
        stk_we     = 1'b1;
        stk_waddr  = clr_cnt_r;
        stk_wdata  = stk_init;
      end
      S_A_CHK: begin
        mul_a = BC_W'(cur_idx_r);
        if (size_bad) begin
          fin        = 1'b1;
          fin_status = ST_BAD_SIZE;
        end
      end
      S_A_CUR: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(cfg.base) + DVD_W'(fp_q);
      end
      S_A_POP: begin
        if (free_cnt_r == '0) begin
          fin        = 1'b1;
          fin_status = ST_NO_BLOCK;
        end
      end
      S_A_POP_RD: mul_a = BC_W'(stk_q);
      S_A_POP_MUL: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(cfg.base) + DVD_W'(prod_r);
      end
      S_A_FIT: begin
        if (fits) begin
          fin       = 1'b1;
          fin_grant = 1'b1;
          fp_we     = 1'b1;
          live_we   = 1'b1;
        end else if (fresh_r) begin
          // even an empty block cannot hold the aligned request
          fin        = 1'b1;
          fin_status = ST_BAD_SIZE;
        end
      end
      S_F_CHK: mul_a = cfg.cnt;
      S_F_RANGE: begin
        if (range_bad) begin
          fin        = 1'b1;
          fin_status = ST_BAD_FREE;
        end else begin
          div_go = 1'b1;
        end
      end
      S_F_UPD: begin
        fin = 1'b1;
        if (live_zero) begin
          fin_status = ST_BAD_FREE;
        end else begin
          live_we    = 1'b1;
          live_wdata = live_q - LIVE_W'(1);
          stk_we     = push;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_cnt_r  <= '0;
      cur_idx_r   <= '0;
      cur_vld_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= fin;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_last) free_cnt_r <= FC_W'(cfg.cnt);
      end
      if (pop_commit) begin
        free_cnt_r <= free_cnt_r - FC_W'(1);
        cur_idx_r  <= idx_r;
        cur_vld_r  <= 1'b1;
      end
      if (push)     free_cnt_r <= free_cnt_r + FC_W'(1);
      if (drop_cur) cur_vld_r  <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    unique case (state_r)
      S_A_CHK: begin
        idx_r   <= cur_idx_r;
        fresh_r <= 1'b0;
        prod_r  <= prod_nxt;
      end
      S_A_CUR_RD:  end_r <= END_W'(prod_r) + END_W'(cfg.bs);
      S_A_CUR:     off_r <= OFFS_W'(fp_q);
      S_A_POP_RD: begin
        idx_r   <= stk_q;
        fresh_r <= 1'b1;
        prod_r  <= prod_nxt;
      end
      S_A_POP_MUL: begin
        end_r <= END_W'(prod_r) + END_W'(cfg.bs);
        off_r <= prod_r;
      end
      S_A_DIV:     if (div_done) got_r <= got_nxt;
      S_F_CHK:     prod_r <= prod_nxt;
      S_F_DIV:     if (div_done) idx_r <= IDX_W'(div_quo);
      default: ;
    endcase
    if (fin) begin
      res_r.status       <= fin_status;
      res_r.offset       <= fin_grant ? got_r[OFF_W-1:0] : '0;
      res_r.granted_size <= fin_grant ? req_r.size : '0;
    end
  end

  // fill pointers, read at the current block
  always_ff @(posedge clk) begin
    if (fp_we) fp_mem[idx_r] <= fp_wdata;
    fp_q <= fp_mem[cur_idx_r];
  end

  // free stack, read at its top
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[stk_raddr];
  end

  // live allocation counts
  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_waddr] <= live_wdata;
    live_q <= live_mem[idx_r];
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== hdl/block_bump_allocator_top.sv =====
// Block bump allocator top level: configuration registers and request port.
// One request is taken at a time, at a rising edge with start high and busy
// low; busy then stays high until the result is ready. The result appears on
// out_data for exactly one cycle, marked by out_valid, and must be taken then.
// The shared 49-step serial divider finds the alignment remainder and the
// block index of a free; an allocate uses it once, or twice when the current
// block lacks room and a fresh block is tried. Early rejects (bad size, empty
// stack with no current block, out-of-range free) answer without the divider.
// After reset and after every write to a known register the block is busy
// while it resets its live-count table and free stack.
`include "block_bump_allocator_top_macros.svh"

module block_bump_allocator_top import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bba_in_t              in_data,
  output logic                 out_valid,
  output bba_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_wdata
);

  localparam int FC_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (FC_W > BC_W) ? FC_W : BC_W;

  logic [BASE_W-1:0] base_r;
  logic [BS_W-1:0]   bs_r;
  logic [BC_W-1:0]   bc_r;
  logic              cfg_hit;
  bba_cfg_t          cfg_eff;
  logic              res_fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      bs_r   <= BS_RST;
      bc_r   <= BC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:   base_r <= cfg_wdata;
        CFG_BSIZE:  bs_r   <= cfg_wdata[BS_W-1:0];
        CFG_BCOUNT: bc_r   <= cfg_wdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the allocator
  assign cfg_hit = cfg_we && (cfg_index == CFG_BASE || cfg_index == CFG_BSIZE ||
                              cfg_index == CFG_BCOUNT);

  always_comb begin
    cfg_eff.base = base_r;
    priority if (bs_r == '0)    cfg_eff.bs = BS_W'(1);
    else if (bs_r > BS_MAX)     cfg_eff.bs = BS_MAX;
    else                        cfg_eff.bs = bs_r;
    priority if (bc_r == '0)                          cfg_eff.cnt = BC_W'(1);
    else if (CMP_W'(bc_r) > CMP_W'(MAX_BLOCKS))       cfg_eff.cnt = BC_W'(MAX_BLOCKS);
    else                                              cfg_eff.cnt = bc_r;
  end

  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (cfg_hit),
    .cfg       (cfg_eff),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (out_data)
  );

  assign res_fail = out_valid && (out_data.status != ST_OK);

  `BBA_ASSERT_NOW(a_result_after_work, out_valid, $past(busy))
  `BBA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `BBA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `BBA_ASSERT_NOW(a_fail_is_empty, res_fail, out_data.offset == '0 && out_data.granted_size == '0)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for the block bump allocator: queued request driver, allocation predictor, checker
module tb_top;
  import bba_pkg::*;

  typedef longint unsigned u64_t;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int DRAIN_CYCLES = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  bba_in_t              in_data = '0;
  logic                 out_valid;
  bba_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0]    cfg_wdata = '0;

  // allocator shadow state
  logic [BASE_W-1:0] reg_base;
  logic [BS_W-1:0]   reg_bsize;
  logic [BC_W-1:0]   reg_bcount;
  logic [5:0]        free_blocks [NBLK];
  int unsigned       free_depth;
  logic [31:0]       fill_ptr [NBLK];
  logic [LIVE_W-1:0] live_cnt [NBLK];
  int unsigned       cur_blk;
  bit                cur_blk_ok;

  bba_in_t          req_queue [$];
  bba_out_t         due_results [$];
  logic [OFF_W-1:0] granted_offs [$];
  int               errors = 0;
  int unsigned      send_idle_pct = 0;
  bit               hold_tx = 1'b0;

  block_bump_allocator_top #(.MAX_BLOCKS(NBLK)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  function automatic u64_t eff_bsize();
    if (reg_bsize == '0) return 1;
    if (reg_bsize > BS_MAX) return u64_t'(BS_MAX);
    return u64_t'(reg_bsize);
  endfunction

  function automatic u64_t eff_blocks();
    if (reg_bcount == '0) return 1;
    if (reg_bcount > NBLK) return NBLK;
    return u64_t'(reg_bcount);
  endfunction

  function automatic void clear_tables();
    u64_t n;
    n = eff_blocks();
    for (int i = 0; i < NBLK; i++) begin
      free_blocks[i] = (i < n) ? 6'(n - 1 - i) : 6'd0;
      fill_ptr[i] = '0;
      live_cnt[i] = '0;
    end
    free_depth = int'(n);
    cur_blk = 0;
    cur_blk_ok = 1'b0;
  endfunction

  // round so that base + offset lands on a multiple of the alignment
  function automatic u64_t round_up(u64_t off, u64_t al);
    u64_t a, adr, r;
    a = (al == 0) ? 1 : al;
    adr = reg_base + off;
    r = adr % a;
    if (r != 0) adr += a - r;
    return adr - reg_base;
  endfunction

  function automatic bit room_in(int unsigned idx, u64_t from, u64_t sz, u64_t al);
    return round_up(from, al) + sz <= (u64_t'(idx) + 1) * eff_bsize();
  endfunction

  function automatic bba_out_t alloc_outcome(bba_in_t rq);
    bba_out_t    res;
    u64_t        bs, n, sz, al, got, from;
    int unsigned idx;
    res = '0;
    res.status = ST_OK;
    bs = eff_bsize();
    n = eff_blocks();
    sz = u64_t'(rq.size);
    al = u64_t'(rq.alignment);
    if (rq.req_type == REQ_ALLOC) begin
      if (sz == 0 || sz >= bs) begin
        res.status = ST_BAD_SIZE;
        return res;
      end
      if (cur_blk_ok && room_in(cur_blk, u64_t'(fill_ptr[cur_blk]), sz, al)) begin
        idx = cur_blk;
      end else begin
        if (free_depth == 0) begin
          res.status = ST_NO_BLOCK;
          return res;
        end
        idx = free_blocks[free_depth - 1];
        from = u64_t'(idx) * bs;
        // fresh block cannot hold the aligned request: nothing is popped
        if (!room_in(idx, from, sz, al)) begin
          res.status = ST_BAD_SIZE;
          return res;
        end
        free_depth--;
        fill_ptr[idx] = from[31:0];
        cur_blk = idx;
        cur_blk_ok = 1'b1;
      end
      got = round_up(u64_t'(fill_ptr[idx]), al);
      fill_ptr[idx] = 32'(got + sz);
      live_cnt[idx] = live_cnt[idx] + 1'b1;
      res.offset = got[OFF_W-1:0];
      res.granted_size = rq.size;
      granted_offs.push_back(res.offset);
    end else begin
      if (u64_t'(rq.free_offset) >= n * bs) begin
        res.status = ST_BAD_FREE;
        return res;
      end
      idx = int'(u64_t'(rq.free_offset) / bs);
      if (idx >= NBLK || live_cnt[idx] == '0) begin
        res.status = ST_BAD_FREE;
        return res;
      end
      live_cnt[idx] = live_cnt[idx] - 1'b1;
      if (live_cnt[idx] == '0) begin
        if (cur_blk_ok && cur_blk == idx) cur_blk_ok = 1'b0;
        if (free_depth < NBLK) begin
          free_blocks[free_depth] = idx[5:0];
          free_depth++;
        end
      end
    end
    return res;
  endfunction

  function automatic bba_in_t make_request();
    bba_in_t          rq;
    u64_t             bs, span, cap;
    int unsigned      pick, k;
    logic [ALIGN_W-1:0] al;
    bs = eff_bsize();
    span = eff_blocks() * bs;
    pick = $urandom_range(99);
    rq = '0;
    rq.size = SIZE_W'($urandom());
    rq.alignment = ALIGN_W'($urandom());
    if (pick < 10) begin
      // noise over the full field ranges
      rq.req_type = bba_req_t'($urandom_range(1));
      rq.free_offset = OFF_W'($urandom());
    end else if (pick < 45 && granted_offs.size() != 0) begin
      k = $urandom_range(granted_offs.size() - 1);
      rq.req_type = REQ_FREE;
      rq.free_offset = granted_offs[k];
      granted_offs.delete(k);
    end else if (pick < 50) begin
      rq.req_type = REQ_FREE;
      rq.free_offset = OFF_W'($urandom_range(32'(span - 1)));
    end else begin
      rq.req_type = REQ_ALLOC;
      if (bs <= 1) begin
        rq.size = SIZE_W'($urandom_range(3));
      end else begin
        cap = (bs > 12 && $urandom_range(9) != 0) ? bs / 6 : bs - 1;
        rq.size = SIZE_W'($urandom_range(1, 32'(cap)));
      end
      k = $urandom_range(9);
      if (k < 6) begin
        al = ALIGN_W'(1) << $urandom_range(16);
        while (al > 1 && u64_t'(al) > bs) al = al >> 1;
      end else if (k < 9) begin
        al = ALIGN_W'($urandom_range(1, 100));
      end else begin
        al = ALIGN_W'($urandom());
      end
      rq.alignment = al;
    end
    return rq;
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (req_queue.size() != 0 || start || due_results.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_reg(bba_cfg_idx_t idx, logic [BASE_W-1:0] val);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BASE:   reg_base = val;
      CFG_BSIZE:  reg_bsize = val[BS_W-1:0];
      CFG_BCOUNT: reg_bcount = val[BC_W-1:0];
      default: ;
    endcase
    clear_tables();
    granted_offs.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [BASE_W-1:0] base, logic [BS_W-1:0] bsz, logic [BC_W-1:0] cnt);
    write_reg(CFG_BASE, base);
    write_reg(CFG_BSIZE, BASE_W'(bsz));
    write_reg(CFG_BCOUNT, BASE_W'(cnt));
    @(negedge clk);
  endtask

  task automatic push_alloc(int unsigned sz, int unsigned al);
    bba_in_t rq;
    rq = '0;
    rq.req_type = REQ_ALLOC;
    rq.size = SIZE_W'(sz);
    rq.alignment = ALIGN_W'(al);
    req_queue.push_back(rq);
  endtask

  task automatic push_free(int unsigned off);
    bba_in_t rq;
    rq = '0;
    rq.req_type = REQ_FREE;
    rq.free_offset = OFF_W'(off);
    req_queue.push_back(rq);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) due_results.push_back(alloc_outcome(in_data));
      if (!start || !busy) begin
        if (req_queue.size() != 0 && !hold_tx && $urandom_range(99) >= send_idle_pct) begin
          in_data <= req_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    bba_out_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
        if (out_data.offset !== want.offset) begin
          errors++;
          $display("%0t: offset mismatch: expected 0x%0h, actual 0x%0h",
                   $time, want.offset, out_data.offset);
        end
        if (out_data.granted_size !== want.granted_size) begin
          errors++;
          $display("%0t: granted_size mismatch: expected 0x%0h, actual 0x%0h",
                   $time, want.granted_size, out_data.granted_size);
        end
      end
    end
  end

  initial begin
    int unsigned ph, k;
    reg_base = BASE_RST;
    reg_bsize = BS_RST;
    reg_bcount = BC_RST;
    clear_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests on the reset setting
    push_alloc(0, 1);
    push_alloc(24'hFFFFFF, 1);
    push_alloc(65536, 1);
    push_alloc(100, 0);
    push_alloc(65535, 1);
    push_alloc(3, 17'h1FFFF);
    push_alloc(7, 65536);
    push_alloc(5, 3);
    push_free(100);
    push_free(0);
    push_free(30'h3FFFFFFF);
    push_free(131079);
    push_free(131082);

    // one block only: fresh block too small, then stack empty
    set_regs(48'd3, 25'd100, 7'd0);
    push_alloc(50, 64);
    push_alloc(60, 1);
    push_alloc(60, 1);
    push_free(0);
    push_free(100);
    push_alloc(99, 1);

    // zero block size and an oversized count
    set_regs(48'd3, 25'd0, 7'd127);
    push_alloc(1, 1);
    push_free(0);

    // largest block size and base
    set_regs(48'hFFFF_FFFF_FFFF, 25'h1FFFFFF, 7'd64);
    push_alloc(24'hFFFFFF, 1);
    push_alloc(24'hFFFFFF, 65536);
    push_free(30'h3FFFFFFF);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs('0, 25'd65536, 7'd64);
        1: set_regs(BASE_W'({$urandom(), $urandom()}), BS_W'($urandom_range(16, 4096)),
                    BC_W'($urandom_range(1, 4)));
        2: set_regs(48'hFFFF_FFFF_FFFF, 25'h1FFFFFF, 7'd127);
        3: set_regs(BASE_W'({$urandom(), $urandom()}), BS_W'($urandom_range(2, 64)), 7'd64);
        4: set_regs('0, 25'd1000, 7'd1);
        default: set_regs(BASE_W'({$urandom(), $urandom()}),
                          ($urandom_range(1) == 0) ? BS_W'($urandom_range(2, 5000))
                                                   : BS_W'($urandom_range(2, 25'h1000000)),
                          BC_W'($urandom_range(127)));
      endcase
      // receiver cannot stall; the sender idles 80% of the time in phases 1 and 5, 12% in 3 and 7
      send_idle_pct = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 12 : 0;
      for (k = 0; k < 100; k++) begin
        while (req_queue.size() > 1) @(negedge clk);
        if ((ph == 2 || ph == 5) && k == 50) begin
          // stop sending until everything in flight has come back
          hold_tx = 1'b1;
          while (start || due_results.size() != 0) @(negedge clk);
          hold_tx = 1'b0;
        end
        req_queue.push_back(make_request());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== block_bump_allocator_top.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_div.sv
hdl/bba_ctrl.sv
hdl/block_bump_allocator_top.sv
tb/sv/tb_top.sv
